>>> src/tee_pkg.sv
package tee_pkg;

   localparam int COLUMNS_DEFAULT = 15;
   localparam int ELECTRODES      = 13;
   localparam int MASK_W          = 15;
   localparam int CSR_DATA_W      = 15;
   localparam int CSR_INDEX_W     = 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_NOTE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESENT_MASK   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIDI_CHANNEL   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CC_NUMBER      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_VELOCITY = 3'd4;

   // reset values
   localparam logic [6:0]        BASE_NOTE_RST      = 7'd36;
   localparam logic [MASK_W-1:0] PRESENT_MASK_RST   = 15'h7FFF;
   localparam logic [3:0]        MIDI_CHANNEL_RST   = 4'd0;
   localparam logic [6:0]        CC_NUMBER_RST      = 7'd74;
   localparam logic [6:0]        PRESS_VELOCITY_RST = 7'd127;

   // event kinds
   localparam logic [1:0] EV_NOTE_ON  = 2'd0;
   localparam logic [1:0] EV_CC       = 2'd1;
   localparam logic [1:0] EV_NOTE_OFF = 2'd2;

   localparam logic [6:0] NOTE_MAX = 7'd127;

   typedef struct packed {
      logic [3:0]  column;
      logic [11:0] electrodes;
      logic        next_first;
      logic        read_error;
   } req_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [3:0] channel_out;
      logic [6:0] data_first;
      logic [6:0] data_second;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic item_ok;
      logic out_free;
      logic final_step;
   } status_type;

   // floor(e*127/12)
   function automatic logic [6:0] cc_value(input logic [3:0] e);
      logic [6:0] v;
      case (e)
         4'd0:    v = 7'd0;
         4'd1:    v = 7'd10;
         4'd2:    v = 7'd21;
         4'd3:    v = 7'd31;
         4'd4:    v = 7'd42;
         4'd5:    v = 7'd52;
         4'd6:    v = 7'd63;
         4'd7:    v = 7'd74;
         4'd8:    v = 7'd84;
         4'd9:    v = 7'd95;
         4'd10:   v = 7'd105;
         4'd11:   v = 7'd116;
         4'd12:   v = 7'd127;
         default: v = 7'd0;
      endcase
      return v;
   endfunction

endpackage

>>> src/tee_ctrl.sv
module tee_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tee_pkg::status_type  status,
   output tee_pkg::cmd_type     cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = status.item_ok;
               if (status.item_ok) state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = status.out_free;
            if (status.out_free && status.final_step) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> src/tee_dp.sv
module tee_dp #(
   parameter int COLUMNS = tee_pkg::COLUMNS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tee_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tee_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_write_en,
   input  logic [tee_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tee_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  tee_pkg::cmd_type                    cmd,
   output tee_pkg::status_type                 status
);

   localparam int IDX_W = $clog2(COLUMNS);
   localparam int E_N   = tee_pkg::ELECTRODES;
   localparam logic [3:0] LAST_E = 4'(E_N - 1);

   // configuration
   logic [6:0]                  base_note_ff;
   logic [tee_pkg::MASK_W-1:0]  present_mask_ff;
   logic [3:0]                  midi_channel_ff;
   logic [6:0]                  cc_number_ff;
   logic [6:0]                  press_velocity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_note_ff      <= tee_pkg::BASE_NOTE_RST;
         present_mask_ff   <= tee_pkg::PRESENT_MASK_RST;
         midi_channel_ff   <= tee_pkg::MIDI_CHANNEL_RST;
         cc_number_ff      <= tee_pkg::CC_NUMBER_RST;
         press_velocity_ff <= tee_pkg::PRESS_VELOCITY_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            tee_pkg::CSR_BASE_NOTE:      base_note_ff      <= csr_wdata[6:0];
            tee_pkg::CSR_PRESENT_MASK:   present_mask_ff   <= csr_wdata[14:0];
            tee_pkg::CSR_MIDI_CHANNEL:   midi_channel_ff   <= csr_wdata[3:0];
            tee_pkg::CSR_CC_NUMBER:      cc_number_ff      <= csr_wdata[6:0];
            tee_pkg::CSR_PRESS_VELOCITY: press_velocity_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // column qualification
   logic [15:0]      mask_ext;
   logic [3:0]       col;
   logic [4:0]       col_next;
   logic             col_ok, next_ok;
   logic [IDX_W-1:0] col_idx;
   logic [E_N-1:0]   now_bits;
   logic [7:0]       note_sum;
   logic [6:0]       note_val;

   assign mask_ext = {1'b0, present_mask_ff};
   assign col      = req_payload.column;
   assign col_next = 5'(col) + 5'd1;
   assign col_idx  = IDX_W'(col);
   assign col_ok   = (32'(col) < COLUMNS) && (col != 4'd15) && mask_ext[col];
   assign next_ok  = (32'(col_next) < COLUMNS) && (col_next < 5'd15)
                     && mask_ext[col_next[3:0]];
   assign now_bits = {next_ok & req_payload.next_first, req_payload.electrodes};
   assign note_sum = 8'(base_note_ff) + 8'(col);
   assign note_val = (note_sum > 8'(tee_pkg::NOTE_MAX)) ? tee_pkg::NOTE_MAX : note_sum[6:0];

   assign status.item_ok = col_ok && !req_payload.read_error;

   // per-column touch history
   logic [E_N-1:0] prev_ff [COLUMNS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COLUMNS; i++) prev_ff[i] <= '0;
      end else if (cmd.load) begin
         prev_ff[col_idx] <= now_bits;
      end
   end

   // scan registers
   logic [E_N-1:0] now_ff, changed_ff;
   logic [6:0]     note_ff;
   logic [3:0]     e_ff, e_in;
   logic           phase_ff, phase_in;

   logic           chg, press, advance, above;
   logic [E_N-1:0] above_bits;

   assign chg        = changed_ff[e_ff];
   assign press      = now_ff[e_ff];
   assign advance    = !chg || !press || phase_ff;
   assign above_bits = changed_ff >> e_ff;
   assign above      = |above_bits[E_N-1:1];

   assign status.final_step = (e_ff == LAST_E) && advance;

   always_comb begin
      e_in     = e_ff;
      phase_in = phase_ff;
      if (cmd.load) begin
         e_in     = '0;
         phase_in = 1'b0;
      end else if (cmd.step) begin
         if (advance) begin
            e_in     = e_ff + 4'd1;
            phase_in = 1'b0;
         end else begin
            phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff     <= '0;
         phase_ff <= 1'b0;
      end else begin
         e_ff     <= e_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff     <= now_bits;
         changed_ff <= now_bits ^ prev_ff[col_idx];
         note_ff    <= note_val;
      end
   end

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   tee_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             emit;

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign emit            = cmd.step && chg;

   always_comb begin
      rsp_data_in             = rsp_data_ff;
      rsp_valid_in            = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.channel_out = midi_channel_ff;
         rsp_data_in.last        = advance && !above;
         if (!press) begin
            rsp_data_in.event_kind  = tee_pkg::EV_NOTE_OFF;
            rsp_data_in.data_first  = note_ff;
            rsp_data_in.data_second = 7'd0;
         end else if (!phase_ff) begin
            rsp_data_in.event_kind  = tee_pkg::EV_NOTE_ON;
            rsp_data_in.data_first  = note_ff;
            rsp_data_in.data_second = press_velocity_ff;
         end else begin
            rsp_data_in.event_kind  = tee_pkg::EV_CC;
            rsp_data_in.data_first  = cc_number_ff;
            rsp_data_in.data_second = tee_pkg::cc_value(e_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

>>> src/touch_edge_midi_event_encoder_top.sv
// Channel | Direction | Beat
// req     | in        | one scanned column (column, electrodes, next_first, read_error)
// rsp     | out       | one MIDI event (kind, channel, two data bytes, last)
// csr     | in        | register write: index, data, no wait
//
// A column is taken, then the controller walks the 13 electrodes in order,
// with an extra step for each press (note-on, then CC); req is ready
// again only after the walk. Errored or absent columns are accepted
// without a walk.
// Synchronous active-high reset clears touch history and loads register
// defaults. rsp stalls hold the walk on the single output register.
module touch_edge_midi_event_encoder_top #(
   parameter int COLUMNS = tee_pkg::COLUMNS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tee_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tee_pkg::rsp_type                rsp_payload,
   input  logic                            csr_write_en,
   input  logic [tee_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tee_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   tee_pkg::cmd_type    cmd;
   tee_pkg::status_type status;

   tee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tee_dp #(
      .COLUMNS (COLUMNS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status)
   );

endmodule
